// ----- rtl/json_string_unescape_utf8_assert.svh -----
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// Immediate implication: the consequent holds in the same cycle.
`define JSU_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: the consequent holds in the next cycle.
`define JSU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/jsu_pkg.sv -----
package jsu_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [3:0] {
    ST_BYTE       = 4'd0,
    ST_CLOSED     = 4'd1,
    ST_NO_OPEN    = 4'd2,
    ST_UNTERM     = 4'd3,
    ST_CTRL_CHAR  = 4'd4,
    ST_UNTERM_ESC = 4'd5,
    ST_BAD_ESC    = 4'd6,
    ST_TRUNC_U    = 4'd7,
    ST_BAD_HEX    = 4'd8,
    ST_LONE_HIGH  = 4'd9,
    ST_BAD_LOW    = 4'd10,
    ST_LONE_LOW   = 4'd11
  } status_e;

  // One request from the front to the back: an error or closing status,
  // a raw byte, or a code point to be encoded as UTF-8.
  typedef struct packed {
    status_e     status;
    logic        raw;
    logic [20:0] cp;
  } cmd_t;

endpackage

// ----- rtl/json_string_unescape_utf8.sv -----
// A request is written to the queue, then loaded into the back's current register and
// then its output register. Throughput: one input byte per cycle while the queue is not
// full; the encoder sends a code point as one to four UTF-8 bytes, one per ready cycle.
// The four-entry request queue lets input run ahead of a stalled or busy output.
// Reset is asynchronous and active low; it empties the queue and returns to idle.
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [3:0] status_o,
  output logic       last_o
);

  logic accept;
  logic push;
  logic full;
  logic pop;
  logic q_valid;
  cmd_t cmd_in;
  cmd_t cmd_head;

  assign in_ready_o = ~full;
  assign accept     = in_valid_i & ~full;

  jsu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .ch_i          (ch_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  jsu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd_in),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (cmd_head)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (cmd_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

// ----- rtl/jsu_front.sv -----
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] ch_i,
  input  logic       end_of_text_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_STR     = 3'd1,
    M_ESC     = 3'd2,
    M_HEX     = 3'd3,
    M_WANT_BS = 3'd4,
    M_WANT_U  = 3'd5,
    M_SKIP    = 3'd6
  } mode_e;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;

  mode_e       mode_q, mode_d;
  logic [1:0]  count_q, count_d;
  logic [15:0] accum_q, accum_d;
  logic [9:0]  high_q, high_d;
  logic        second_q, second_d;

  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [15:0] hex_acc;
  logic        push;
  cmd_t        cmd;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    priority if (ch_i >= 8'h30 && ch_i <= 8'h39) begin
      hex_d = ch_i[3:0];
    end else if ((ch_i >= 8'h61 && ch_i <= 8'h66) || (ch_i >= 8'h41 && ch_i <= 8'h46)) begin
      hex_d = ch_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_acc = {accum_q[11:0], hex_d};

  always_comb begin
    mode_d   = mode_q;
    count_d  = count_q;
    accum_d  = accum_q;
    high_d   = high_q;
    second_d = second_q;
    push     = 1'b0;
    cmd      = '{status: ST_BYTE, raw: 1'b1, cp: {13'd0, ch_i}};

    if (end_of_text_i) begin
      second_d = 1'b0;
      count_d  = 2'd0;
      mode_d   = M_IDLE;
      cmd.cp   = '0;
      unique case (mode_q)
        M_STR: begin
          push       = 1'b1;
          cmd.status = ST_UNTERM;
        end
        M_ESC: begin
          push       = 1'b1;
          cmd.status = ST_UNTERM_ESC;
        end
        M_HEX: begin
          push       = 1'b1;
          cmd.status = ST_TRUNC_U;
        end
        M_WANT_BS, M_WANT_U: begin
          push       = 1'b1;
          cmd.status = ST_LONE_HIGH;
        end
        default: ;
      endcase
    end else begin
      unique case (mode_q)
        M_IDLE: begin
          if (ch_i == CH_QUOTE) begin
            mode_d = M_STR;
          end else begin
            mode_d     = M_SKIP;
            push       = 1'b1;
            cmd.status = ST_NO_OPEN;
            cmd.cp     = '0;
          end
        end
        M_STR: begin
          priority if (ch_i == CH_QUOTE) begin
            mode_d     = M_IDLE;
            push       = 1'b1;
            cmd.status = ST_CLOSED;
            cmd.cp     = '0;
          end else if (ch_i == CH_BSL) begin
            mode_d = M_ESC;
          end else if (ch_i < 8'h20) begin
            mode_d     = M_SKIP;
            push       = 1'b1;
            cmd.status = ST_CTRL_CHAR;
            cmd.cp     = '0;
          end else begin
            push = 1'b1;
          end
        end
        M_ESC: begin
          mode_d = M_STR;
          push   = 1'b1;
          unique case (ch_i)
            CH_QUOTE, CH_BSL, CH_SLASH: ;
            8'h62: cmd.cp = 21'h08;
            8'h66: cmd.cp = 21'h0C;
            8'h6E: cmd.cp = 21'h0A;
            8'h72: cmd.cp = 21'h0D;
            8'h74: cmd.cp = 21'h09;
            CH_U: begin
              push     = 1'b0;
              mode_d   = M_HEX;
              count_d  = 2'd0;
              accum_d  = 16'd0;
              second_d = 1'b0;
            end
            default: begin
              mode_d     = M_SKIP;
              cmd.status = ST_BAD_ESC;
              cmd.cp     = '0;
            end
          endcase
        end
        M_HEX: begin
          if (!hex_ok) begin
            second_d   = 1'b0;
            mode_d     = M_SKIP;
            push       = 1'b1;
            cmd.status = ST_BAD_HEX;
            cmd.cp     = '0;
          end else begin
            accum_d = hex_acc;
            if (count_q == 2'd3) begin
              count_d = 2'd0;
              if (!second_q) begin
                priority if (hex_acc[15:10] == 6'b110110) begin
                  high_d = hex_acc[9:0];
                  mode_d = M_WANT_BS;
                end else if (hex_acc[15:10] == 6'b110111) begin
                  mode_d     = M_SKIP;
                  push       = 1'b1;
                  cmd.status = ST_LONE_LOW;
                  cmd.cp     = '0;
                end else begin
                  mode_d  = M_STR;
                  push    = 1'b1;
                  cmd.raw = 1'b0;
                  cmd.cp  = {5'd0, hex_acc};
                end
              end else begin
                second_d = 1'b0;
                push     = 1'b1;
                if (hex_acc[15:10] != 6'b110111) begin
                  mode_d     = M_SKIP;
                  cmd.status = ST_BAD_LOW;
                  cmd.cp     = '0;
                end else begin
                  mode_d  = M_STR;
                  cmd.raw = 1'b0;
                  cmd.cp  = {({1'b0, high_q} + 11'h040), hex_acc[9:0]};
                end
              end
            end else begin
              count_d = count_q + 2'd1;
            end
          end
        end
        M_WANT_BS: begin
          if (ch_i == CH_BSL) begin
            mode_d = M_WANT_U;
          end else begin
            mode_d     = M_SKIP;
            push       = 1'b1;
            cmd.status = ST_LONE_HIGH;
            cmd.cp     = '0;
          end
        end
        M_WANT_U: begin
          if (ch_i == CH_U) begin
            mode_d   = M_HEX;
            count_d  = 2'd0;
            accum_d  = 16'd0;
            second_d = 1'b1;
          end else begin
            mode_d     = M_SKIP;
            push       = 1'b1;
            cmd.status = ST_LONE_HIGH;
            cmd.cp     = '0;
          end
        end
        default: begin
          if (ch_i == CH_QUOTE) begin
            mode_d = M_STR;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      count_q  <= 2'd0;
      accum_q  <= 16'd0;
      high_q   <= 10'd0;
      second_q <= 1'b0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      count_q  <= count_d;
      accum_q  <= accum_d;
      high_q   <= high_d;
      second_q <= second_d;
    end
  end

  assign push_o = accept_i & push;
  assign cmd_o  = cmd;

endmodule

// ----- rtl/jsu_fifo.sv -----
module jsu_fifo
  import jsu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  cmd_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   cnt_q;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/jsu_back.sv -----
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [3:0] status_o,
  output logic       last_o
);

  logic            cur_valid_q;
  cmd_t            cur_q;
  logic [1:0]      idx_q;
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic [3:0]      status_q;
  logic            last_q;

  logic [3:0][7:0] enc;
  logic [1:0]      last_idx;
  logic            load_out;
  logic            cur_done;
  logic            pop;

  always_comb begin
    enc      = '0;
    last_idx = 2'd0;
    priority if (cur_q.status != ST_BYTE) begin
      enc[0] = 8'd0;
    end else if (cur_q.raw) begin
      enc[0] = cur_q.cp[7:0];
    end else if (cur_q.cp[20:7] == '0) begin
      enc[0] = {1'b0, cur_q.cp[6:0]};
    end else if (cur_q.cp[20:11] == '0) begin
      last_idx = 2'd1;
      enc[0]   = {3'b110, cur_q.cp[10:6]};
      enc[1]   = {2'b10, cur_q.cp[5:0]};
    end else if (cur_q.cp[20:16] == '0) begin
      last_idx = 2'd2;
      enc[0]   = {4'b1110, cur_q.cp[15:12]};
      enc[1]   = {2'b10, cur_q.cp[11:6]};
      enc[2]   = {2'b10, cur_q.cp[5:0]};
    end else begin
      last_idx = 2'd3;
      enc[0]   = {5'b11110, cur_q.cp[20:18]};
      enc[1]   = {2'b10, cur_q.cp[17:12]};
      enc[2]   = {2'b10, cur_q.cp[11:6]};
      enc[3]   = {2'b10, cur_q.cp[5:0]};
    end
  end

  assign load_out = cur_valid_q & (~out_valid_q | out_ready_i);
  assign cur_done = load_out & (idx_q == last_idx);
  assign pop      = cmd_valid_i & (~cur_valid_q | cur_done);

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= cmd_i;
    end
    if (load_out) begin
      out_byte_q <= enc[idx_q];
      status_q   <= cur_q.status;
      last_q     <= (idx_q == last_idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid_q <= 1'b1;
        idx_q       <= 2'd0;
      end else if (cur_done) begin
        cur_valid_q <= 1'b0;
        idx_q       <= 2'd0;
      end else if (load_out) begin
        idx_q <= idx_q + 2'd1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

// ----- rtl/jsu_chk.sv -----
`include "json_string_unescape_utf8_assert.svh"

module jsu_chk
  import jsu_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] ch_i,
  input logic       end_of_text_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic [3:0] status_o,
  input logic       last_o
);

  `JSU_ASSERT_SAME(a_err_byte_zero, out_valid_o && status_o != ST_BYTE, out_byte_o == 8'd0, "error result carries a nonzero byte")
  `JSU_ASSERT_SAME(a_err_is_last, out_valid_o && status_o != ST_BYTE, last_o, "status result is not marked last")
  `JSU_ASSERT_SAME(a_status_range, out_valid_o, status_o <= ST_LONE_LOW, "status code out of range")
  `JSU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_byte_o) && $stable(status_o) && $stable(last_o), "stalled result changed")

endmodule

bind json_string_unescape_utf8 jsu_chk u_chk (.*);
